// ----- rtl/npci_pkg.sv -----
// Shared types and constants for the nearest palette color index unit.
// Holds the built-in palette, field widths and the candidate word type.
// No dependencies.
package npci_pkg;

  localparam int unsigned WORD_W           = 32;
  localparam int unsigned CHAN_W           = 8;
  localparam int unsigned NUM_CHAN         = 4;
  localparam int unsigned SQ_W             = 2 * CHAN_W;
  localparam int unsigned DIST_W           = 18;
  localparam int unsigned IDX_W            = 4;
  localparam int unsigned BUILTIN_ENTRIES  = 16;
  localparam int unsigned PALETTE_SIZE_DEF = 16;

  // 4 * 255 * 255, largest distance any real entry can give
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd260100;
  // filler leaves of the min tree; above DIST_MAX so it never wins
  localparam logic [DIST_W-1:0] DIST_PAD = '1;

  // 0xWWRRGGBB
  localparam logic [WORD_W-1:0] PALETTE [BUILTIN_ENTRIES] = '{
    32'h0000_0000, 32'h0022_2222, 32'h0066_6666, 32'hFFFF_FFFF,
    32'h00FF_FF00, 32'h00FF_6600, 32'h00FF_0000, 32'h00FF_00FF,
    32'h0066_00FF, 32'h0000_00FF, 32'h0000_FFFF, 32'h0000_FF66,
    32'h0000_FF00, 32'h0000_2200, 32'h0099_6633, 32'h0033_2211
  };

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } cand_t;

endpackage

// ----- rtl/npci_dist.sv -----
// Distance pipeline: one lane per palette entry, three register stages
// (channel difference, square, four-channel sum). Depends on npci_pkg.
module npci_dist #(
  parameter int unsigned NUM_LANES = npci_pkg::PALETTE_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [npci_pkg::WORD_W-1:0]       color_i,
  output logic                              valid_o,
  output logic [npci_pkg::DIST_W-1:0]       dist_o [NUM_LANES]
);

  logic [2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [npci_pkg::CHAN_W-1:0] diff_q [npci_pkg::NUM_CHAN];
    logic [npci_pkg::SQ_W-1:0]   sq_q   [npci_pkg::NUM_CHAN];
    logic [npci_pkg::DIST_W-1:0] dist_q;

    for (genvar c = 0; c < npci_pkg::NUM_CHAN; c++) begin : g_chan
      logic [npci_pkg::CHAN_W-1:0] x, y;
      assign x = color_i[c*npci_pkg::CHAN_W +: npci_pkg::CHAN_W];
      assign y = npci_pkg::PALETTE[l][c*npci_pkg::CHAN_W +: npci_pkg::CHAN_W];

      always_ff @(posedge clk_i) begin
        diff_q[c] <= (x > y) ? (x - y) : (y - x);
        sq_q[c]   <= npci_pkg::SQ_W'(diff_q[c]) * npci_pkg::SQ_W'(diff_q[c]);
      end
    end

    always_ff @(posedge clk_i) begin
      dist_q <= npci_pkg::DIST_W'(sq_q[0]) + npci_pkg::DIST_W'(sq_q[1])
              + npci_pkg::DIST_W'(sq_q[2]) + npci_pkg::DIST_W'(sq_q[3]);
    end

    assign dist_o[l] = dist_q;
  end

endmodule

// ----- rtl/npci_min_tree.sv -----
// Registered minimum tree over the lane distances, one compare level per
// stage; strict compare keeps the lower index on ties. Depends on npci_pkg.
module npci_min_tree #(
  parameter int unsigned NUM_LANES = npci_pkg::PALETTE_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [npci_pkg::DIST_W-1:0]   dist_i [NUM_LANES],
  output logic                          valid_o,
  output npci_pkg::cand_t               best_o
);

  // a single lane still gets one level, paired with a filler leaf
  localparam int unsigned LEVELS = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int unsigned PAD    = 1 << LEVELS;

  npci_pkg::cand_t leaf   [PAD];
  npci_pkg::cand_t node_q [1:PAD-1];
  logic [LEVELS-1:0] vld_q;

  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < NUM_LANES) begin : g_real
      assign leaf[j] = '{idx: npci_pkg::IDX_W'(j), distance: dist_i[j]};
    end else begin : g_fill
      assign leaf[j] = '{idx: '0, distance: npci_pkg::DIST_PAD};
    end
  end

  // heap order: node k takes children 2k and 2k+1, leaves take heap positions PAD and up
  for (genvar k = 1; k < PAD; k++) begin : g_node
    npci_pkg::cand_t a, b;
    if (2 * k >= PAD) begin : g_from_leaf
      assign a = leaf[2*k - PAD];
      assign b = leaf[2*k + 1 - PAD];
    end else begin : g_from_node
      assign a = node_q[2*k];
      assign b = node_q[2*k + 1];
    end

    always_ff @(posedge clk_i) begin
      node_q[k] <= (b.distance < a.distance) ? b : a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < LEVELS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[LEVELS-1];
  assign best_o  = node_q[1];

endmodule

// ----- rtl/nearest_palette_color_index_unit.sv -----
// Nearest palette color index unit, top level.
// Uses npci_dist and npci_min_tree; constants from npci_pkg.
//
// Usage:
//   Input: drive color_word_i (W,R,G,B bytes, white in the top byte) and
//   raise start_i; the word is taken at any edge where start_i is high and
//   busy_o is low. busy_o stays low, so a word can go in every cycle.
//   Output: done_o is high for one cycle with palette_index_o and
//   min_distance_o, the nearest built-in palette entry and its squared
//   four-channel distance. Ties go to the lower index.
//   Path from accept to done_o: three stages of per-lane distance
//   (difference, square, sum), then one stage per level of the min tree
//   (at least one tree level).
//   Throughput: one word per cycle, results in input order.
//   Only min(PALETTE_SIZE, 16) entries are searched, entry 0 at least.
//   Reset clears the valid pipeline; words in flight are dropped.
//   The receiver cannot stall: every result shows for exactly one cycle.
module nearest_palette_color_index_unit #(
  parameter int unsigned PALETTE_SIZE = npci_pkg::PALETTE_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [npci_pkg::WORD_W-1:0]       color_word_i,
  output logic                              done_o,
  output logic [npci_pkg::IDX_W-1:0]        palette_index_o,
  output logic [npci_pkg::DIST_W-1:0]       min_distance_o
);

  localparam int unsigned NUM_LANES =
    (PALETTE_SIZE > npci_pkg::BUILTIN_ENTRIES) ? npci_pkg::BUILTIN_ENTRIES :
    (PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE;
  localparam int unsigned LATENCY = 3 + ((NUM_LANES > 1) ? $clog2(NUM_LANES) : 1);

  logic                        accept;
  logic                        dist_vld;
  logic [npci_pkg::DIST_W-1:0] lane_dist [NUM_LANES];
  logic                        tree_vld;
  npci_pkg::cand_t             best;

  // fully pipelined, never backs up
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  npci_dist #(
    .NUM_LANES (NUM_LANES)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .color_i (color_word_i),
    .valid_o (dist_vld),
    .dist_o  (lane_dist)
  );

  npci_min_tree #(
    .NUM_LANES (NUM_LANES)
  ) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_vld),
    .dist_i  (lane_dist),
    .valid_o (tree_vld),
    .best_o  (best)
  );

  assign done_o          = tree_vld;
  assign palette_index_o = best.idx;
  assign min_distance_o  = best.distance;

  a_accept_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted word produced no result");

  a_done_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without a matching accepted word");

  a_dist_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_distance_o <= npci_pkg::DIST_MAX))
    else $error("winning distance came from a filler leaf");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(palette_index_o) < NUM_LANES))
    else $error("palette index beyond searched entries");

endmodule
